[rtl/combined_mwc_random_generator_unit_assert.svh]
// Assertion macros for the combined MWC generator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef COMBINED_MWC_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define COMBINED_MWC_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define CMWC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmwc check failed");

// next-cycle implication
`define CMWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmwc check failed");

`endif

[rtl/cmwc_pkg.sv]
// Shared types and constants of the combined MWC generator.
// No dependencies; used by the top level, cmwc_lane_bank and cmwc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

   localparam int NUM_LANES = 8;
   localparam int LANE_IDX_W = 3;
   localparam int CSR_IDX_W = 4;

   localparam logic [LANE_IDX_W-1:0] LANE_LAST = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 4'd8;
   localparam logic [6:0] MAX_WORDS = 7'd64;

   // lane order: x0, y0, x1, y1, x2, y2, x3, y3 (index 0 at the right)
   localparam logic [7:0][15:0] MULT_RESET = {
      16'd21723, 16'd19074, 16'd24948, 16'd28959,
      16'd19215, 16'd23163, 16'd30903, 16'd18000
   };

   typedef enum logic [1:0] {
      CMD_GENERATE = 2'd0,
      CMD_FORCE    = 2'd1,
      CMD_RESTORE  = 2'd2,
      CMD_NONE     = 2'd3
   } cmwc_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_STEP = 2'd1,
      ST_EMIT = 2'd2
   } cmwc_state_type;

   typedef struct packed {
      logic                  load_seed;
      logic                  restore;
      logic                  step_en;
      logic [LANE_IDX_W-1:0] lane_idx;
      logic                  emit;
      logic                  emit_last;
   } cmwc_ctrl_type;

endpackage

`default_nettype wire

[rtl/cmwc_if.sv]
// Channel interfaces of the combined MWC generator: request, response, register write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cmwc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] seed_x0;
   logic [31:0] seed_y0;
   logic [31:0] seed_x1;
   logic [31:0] seed_y1;
   logic [31:0] seed_x2;
   logic [31:0] seed_y2;
   logic [31:0] seed_x3;
   logic [31:0] seed_y3;
   logic        seed_flag;
   logic [6:0]  word_count;

   modport source(output valid, cmd, seed_x0, seed_y0, seed_x1, seed_y1, seed_x2, seed_y2,
                  seed_x3, seed_y3, seed_flag, word_count, input ready);
   modport sink(input valid, cmd, seed_x0, seed_y0, seed_x1, seed_y1, seed_x2, seed_y2,
                seed_x3, seed_y3, seed_flag, word_count, output ready);
endinterface

interface cmwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] random_word;
   logic        last;
   logic        seeded;

   modport source(output valid, random_word, last, seeded, input ready);
   modport sink(input valid, random_word, last, seeded, output ready);
endinterface

interface cmwc_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/combined_mwc_random_generator_unit.sv]
// Top level of the combined MWC generator: register file, output register, sequencer, lanes.
// Depends on cmwc_pkg, cmwc_if, cmwc_ctrl, cmwc_lane_bank and the assertion macro header.
//
//   channel   dir   handshake     contents
//   req_ch    in    valid/ready   cmd, eight seeds, seed_flag, word_count
//   rsp_ch    out   valid/ready   random_word, last, seeded
//   csr_ch    in    valid/ready   index, data (multipliers, index 0..7)
//
// A generate of n words takes 8 lane steps per word through the one shared
// multiply-add unit, then an emit step for that word.
// Force, restore and unused commands finish in the accept cycle.
// Reset clears lanes, saved copy and flags, and loads the default multipliers.
// A stalled response holds the sequencer in its emit cycle; req_ch is ready only when idle.
`timescale 1ns / 1ps
`default_nettype none
`include "combined_mwc_random_generator_unit_assert.svh"

module combined_mwc_random_generator_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   cmwc_req_if.sink    req_ch,
   cmwc_rsp_if.source  rsp_ch,
   cmwc_csr_if.sink    csr_ch
);
   import cmwc_pkg::*;

   logic [NUM_LANES-1:0][15:0] mult_ff;
   logic [NUM_LANES-1:0][31:0] seed_lanes;
   cmwc_ctrl_type              ctrl;
   logic                       rsp_free;
   logic [31:0]                acc_word;
   logic                       seeded;
   logic                       rsp_valid_ff;
   logic [31:0]                rsp_word_ff;
   logic                       rsp_last_ff;
   logic                       rsp_seeded_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= MULT_RESET;
      end else if (csr_ch.valid && csr_ch.ready && csr_ch.index < CSR_COUNT) begin
         mult_ff[csr_ch.index[LANE_IDX_W-1:0]] <= csr_ch.data;
      end
   end

   assign seed_lanes = {req_ch.seed_y3, req_ch.seed_x3, req_ch.seed_y2, req_ch.seed_x2,
                        req_ch.seed_y1, req_ch.seed_x1, req_ch.seed_y0, req_ch.seed_x0};

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   cmwc_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_cmd        (cmwc_cmd_type'(req_ch.cmd)),
      .req_word_count (req_ch.word_count),
      .rsp_free       (rsp_free),
      .req_ready      (req_ch.ready),
      .ctrl           (ctrl)
   );

   cmwc_lane_bank u_lane_bank (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .seed_lanes (seed_lanes),
      .seed_flag  (req_ch.seed_flag),
      .mult       (mult_ff[ctrl.lane_idx]),
      .acc_word   (acc_word),
      .seeded     (seeded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_word_ff   <= acc_word;
         rsp_last_ff   <= ctrl.emit_last;
         rsp_seeded_ff <= seeded;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.random_word = rsp_word_ff;
   assign rsp_ch.last        = rsp_last_ff;
   assign rsp_ch.seeded      = rsp_seeded_ff;

   `CMWC_ASSERT_NEXT(a_emit_shows, clock, reset, ctrl.emit, rsp_valid_ff)
   `CMWC_ASSERT_IMPL(a_no_step_when_ready, clock, reset, req_ch.ready, !ctrl.step_en && !ctrl.emit)
endmodule

`default_nettype wire

[rtl/cmwc_mac.sv]
// Shared multiply-add unit: one MWC lane step, mult * low16 + high16.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module cmwc_mac (
   input  wire logic [15:0] mult,
   input  wire logic [31:0] value,
   output logic      [31:0] next_value
);
   logic [31:0] prod;

   always_comb begin
      prod       = 32'(mult) * 32'(value[15:0]);
      next_value = prod + {16'h0000, value[31:16]};
   end
endmodule

`default_nettype wire

[rtl/cmwc_lane_bank.sv]
// Lane registers, saved copy, seeded flags and word accumulator.
// Depends on cmwc_pkg and cmwc_mac.
`timescale 1ns / 1ps
`default_nettype none

module cmwc_lane_bank (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cmwc_pkg::cmwc_ctrl_type           ctrl,
   input  wire logic [cmwc_pkg::NUM_LANES-1:0][31:0] seed_lanes,
   input  wire logic                              seed_flag,
   input  wire logic [15:0]                       mult,
   output logic      [31:0]                       acc_word,
   output logic                                   seeded
);
   import cmwc_pkg::*;

   logic [NUM_LANES-1:0][31:0] lane_ff, lane_in;
   logic [NUM_LANES-1:0][31:0] saved_ff, saved_in;
   logic                       seeded_ff, seeded_in;
   logic                       saved_seeded_ff, saved_seeded_in;
   logic [31:0]                acc_ff, acc_in;
   logic [31:0]                mac_out;
   logic [31:0]                contrib;

   cmwc_mac u_mac (
      .mult       (mult),
      .value      (lane_ff[ctrl.lane_idx]),
      .next_value (mac_out)
   );

   always_comb begin
      lane_in         = lane_ff;
      saved_in        = saved_ff;
      seeded_in       = seeded_ff;
      saved_seeded_in = saved_seeded_ff;
      acc_in          = acc_ff;
      // x lanes sit at even indexes and feed the upper half
      contrib = ctrl.lane_idx[0] ? {16'h0000, mac_out[15:0]} : {mac_out[15:0], 16'h0000};
      if (ctrl.load_seed) begin
         saved_in        = lane_ff;
         saved_seeded_in = seeded_ff;
         lane_in         = seed_lanes;
         seeded_in       = seed_flag;
      end
      if (ctrl.restore) begin
         lane_in   = saved_ff;
         seeded_in = saved_seeded_ff;
      end
      if (ctrl.step_en) begin
         lane_in[ctrl.lane_idx] = mac_out;
         acc_in = ((ctrl.lane_idx == '0) ? 32'h0 : acc_ff) ^ contrib;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff         <= '0;
         saved_ff        <= '0;
         seeded_ff       <= 1'b0;
         saved_seeded_ff <= 1'b0;
      end else begin
         lane_ff         <= lane_in;
         saved_ff        <= saved_in;
         seeded_ff       <= seeded_in;
         saved_seeded_ff <= saved_seeded_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_word = acc_ff;
   assign seeded   = seeded_ff;
endmodule

`default_nettype wire

[rtl/cmwc_ctrl.sv]
// Sequencer: decodes requests, walks the eight lanes per word, counts burst words.
// Depends on cmwc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "combined_mwc_random_generator_unit_assert.svh"

module cmwc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire cmwc_pkg::cmwc_cmd_type req_cmd,
   input  wire logic [6:0]             req_word_count,
   input  wire logic                   rsp_free,
   output logic                        req_ready,
   output cmwc_pkg::cmwc_ctrl_type     ctrl
);
   import cmwc_pkg::*;

   cmwc_state_type        state_ff, state_in;
   logic [LANE_IDX_W-1:0] lane_ff, lane_in;
   logic [6:0]            words_left_ff, words_left_in;
   logic                  accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      lane_in       = lane_ff;
      words_left_in = words_left_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_GENERATE && req_word_count != 7'd0) begin
               state_in      = ST_STEP;
               lane_in       = '0;
               words_left_in = (req_word_count > MAX_WORDS) ? MAX_WORDS : req_word_count;
            end
         end
         ST_STEP: begin
            lane_in = lane_ff + 3'd1;
            if (lane_ff == LANE_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               if (words_left_ff == 7'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in      = ST_STEP;
                  lane_in       = '0;
                  words_left_in = words_left_ff - 7'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      ctrl.load_seed = accept && req_cmd == CMD_FORCE;
      ctrl.restore   = accept && req_cmd == CMD_RESTORE;
      ctrl.step_en   = (state_ff == ST_STEP);
      ctrl.lane_idx  = lane_ff;
      ctrl.emit      = (state_ff == ST_EMIT) && rsp_free;
      ctrl.emit_last = (words_left_ff == 7'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lane_ff       <= '0;
         words_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         lane_ff       <= lane_in;
         words_left_ff <= words_left_in;
      end
   end

   `CMWC_ASSERT_NEXT(a_step_to_emit, clock, reset, state_ff == ST_STEP && lane_ff == LANE_LAST, state_ff == ST_EMIT)
   `CMWC_ASSERT_NEXT(a_last_to_idle, clock, reset, ctrl.emit && ctrl.emit_last, state_ff == ST_IDLE)
   `CMWC_ASSERT_IMPL(a_busy_count, clock, reset, state_ff != ST_IDLE, words_left_ff != 7'd0 && words_left_ff <= MAX_WORDS)
endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench of combined_mwc_random_generator_unit: directed and random traffic on the request
// channel, multiplier writes between phases, and every output word checked against a lane model.
// Depends on cmwc_pkg, the channel interfaces in cmwc_if.sv and the block's RTL.
`timescale 1ns / 1ps

module testbench;
   import cmwc_pkg::*;

   localparam logic [3:0] REG_MULT_X0 = 4'd0;
   localparam logic [3:0] REG_INDEX_TOP = 4'd15;

   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int ITEMS_PER_PHASE = 42;
   localparam int NUM_PHASES = 5;

   typedef struct packed {
      cmwc_cmd_type     cmd;
      logic [7:0][31:0] seed;
      logic             seed_flag;
      logic [6:0]       word_count;
   } gen_request_type;

   typedef struct packed {
      logic [31:0] random_word;
      logic        last;
      logic        seeded;
   } word_result_type;

   logic clock = 1'b0;
   logic reset;

   cmwc_req_if req_bus ();
   cmwc_rsp_if rsp_bus ();
   cmwc_csr_if csr_bus ();

   combined_mwc_random_generator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // lane order everywhere: x0, y0, x1, y1, x2, y2, x3, y3
   logic [7:0][15:0] mult_state;
   logic [7:0][31:0] lane_state;
   logic [7:0][31:0] saved_lane_state;
   logic             seeded_state;
   logic             saved_seeded_state;

   word_result_type pending_words[$];
   word_result_type head_word;
   int              error_count = 0;
   int              idle_cycles = 0;
   int              sender_burst_left = 0;
   int              stall_left = 0;
   int              calm_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- lane model
   task automatic advance_lane_model(input gen_request_type item);
      int unsigned     count;
      logic [31:0]     word;
      word_result_type entry;
      case (item.cmd)
         CMD_FORCE: begin
            saved_lane_state = lane_state;
            saved_seeded_state = seeded_state;
            lane_state = item.seed;
            seeded_state = item.seed_flag;
         end
         CMD_RESTORE: begin
            lane_state = saved_lane_state;
            seeded_state = saved_seeded_state;
         end
         CMD_GENERATE: begin
            count = (item.word_count > MAX_WORDS) ? MAX_WORDS : item.word_count;
            for (int k = 0; k < count; k++) begin
               for (int i = 0; i < 8; i++) begin
                  lane_state[i] = {16'h0, mult_state[i]} * {16'h0, lane_state[i][15:0]}
                                  + {16'h0, lane_state[i][31:16]};
               end
               word = '0;
               for (int p = 0; p < 4; p++) begin
                  word ^= {lane_state[2*p][15:0], 16'h0} ^ {16'h0, lane_state[2*p+1][15:0]};
               end
               entry.random_word = word;
               entry.last = (k == count - 1);
               entry.seeded = seeded_state;
               pending_words.push_back(entry);
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic [31:0] pick_seed();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'h0;
      if (r < 20) return 32'hFFFF_FFFF;
      if (r < 30) return {16'h0, 16'($urandom)};
      if (r < 40) return {16'hFFFF, 16'($urandom)};
      return $urandom;
   endfunction

   function automatic logic [6:0] pick_word_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 2) return 7'd0;
      if (r < 70) return 7'($urandom_range(1, 6));
      if (r < 90) return 7'($urandom_range(7, 20));
      if (r < 98) return 7'($urandom_range(21, 64));
      return 7'($urandom_range(65, 127));
   endfunction

   function automatic gen_request_type make_request(input cmwc_cmd_type cmd, input int count);
      gen_request_type item;
      for (int i = 0; i < 8; i++) item.seed[i] = $urandom;
      item.seed_flag = 1'($urandom);
      item.cmd = cmd;
      item.word_count = 7'(count);
      return item;
   endfunction

   function automatic gen_request_type make_force(input logic [31:0] xval,
                                                  input logic [31:0] yval,
                                                  input logic flag);
      gen_request_type item;
      item = make_request(CMD_FORCE, $urandom_range(0, 127));
      for (int p = 0; p < 4; p++) begin
         item.seed[2*p] = xval;
         item.seed[2*p+1] = yval;
      end
      item.seed_flag = flag;
      return item;
   endfunction

   // hold valid across a burst, drop it for a random gap between bursts
   task automatic pace_sender();
      int gap;
      if (sender_burst_left > 0) begin
         sender_burst_left--;
      end else begin
         gap = $urandom_range(0, 10);
         sender_burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_request(input gen_request_type item);
      req_bus.valid <= 1'b1;
      req_bus.cmd <= item.cmd;
      req_bus.seed_x0 <= item.seed[0];
      req_bus.seed_y0 <= item.seed[1];
      req_bus.seed_x1 <= item.seed[2];
      req_bus.seed_y1 <= item.seed[3];
      req_bus.seed_x2 <= item.seed[4];
      req_bus.seed_y2 <= item.seed[5];
      req_bus.seed_x3 <= item.seed[6];
      req_bus.seed_y3 <= item.seed[7];
      req_bus.seed_flag <= item.seed_flag;
      req_bus.word_count <= item.word_count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_lane_model(item);
      pace_sender();
   endtask

   task automatic drain_words();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic settle_for_config();
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [3:0] index, input logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (index < CSR_COUNT) mult_state[index[2:0]] = value;
   endtask

   task automatic program_multipliers(input logic [7:0][15:0] values);
      for (int i = 0; i < 8; i++) write_register(REG_MULT_X0 + 4'(i), values[i]);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_unseeded_generate();
      send_request(make_request(CMD_GENERATE, 3));
   endtask

   task automatic test_seed_extremes();
      send_request(make_force(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send_request(make_request(CMD_GENERATE, 2));
      send_request(make_force(32'h0, 32'h0, 1'b1));
      send_request(make_request(CMD_GENERATE, 1));
      send_request(make_force(32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
      send_request(make_request(CMD_GENERATE, 2));
   endtask

   task automatic test_save_restore();
      send_request(make_force($urandom, $urandom, 1'b1));
      send_request(make_request(CMD_GENERATE, 3));
      send_request(make_force($urandom, $urandom, 1'b0));
      send_request(make_request(CMD_GENERATE, 2));
      send_request(make_request(CMD_RESTORE, 5));
      send_request(make_request(CMD_RESTORE, 9));
      send_request(make_request(CMD_GENERATE, 2));
   endtask

   task automatic test_word_counts();
      send_request(make_request(CMD_GENERATE, 0));
      send_request(make_request(CMD_GENERATE, 1));
      send_request(make_request(CMD_GENERATE, 64));
      send_request(make_request(CMD_GENERATE, 127));
      send_request(make_request(CMD_GENERATE, 65));
      send_request(make_request(CMD_NONE, 4));
   endtask

   task automatic test_register_writes();
      logic [7:0][15:0] values;
      settle_for_config();
      for (int p = 0; p < 4; p++) begin
         values[2*p] = 16'h0;
         values[2*p+1] = 16'hFFFF;
      end
      program_multipliers(values);
      write_register(CSR_COUNT, 16'($urandom));
      write_register(REG_INDEX_TOP, 16'($urandom));
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      send_request(make_force($urandom, $urandom, 1'b1));
      send_request(make_request(CMD_GENERATE, 3));
      settle_for_config();
      program_multipliers(~values);
      send_request(make_request(CMD_GENERATE, 2));
   endtask

   task automatic test_random_traffic();
      logic [7:0][15:0] values;
      gen_request_type  item;
      int unsigned      r;
      int               counted;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         settle_for_config();
         for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 9);
            values[i] = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
         end
         if (phase == 2) values = '1;
         if (phase == NUM_PHASES - 1) values = MULT_RESET;
         program_multipliers(values);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            item = make_request(CMD_GENERATE, pick_word_count());
            r = $urandom_range(0, 99);
            if (r < 55) begin
               if (item.word_count != 0) counted++;
            end else if (r < 80) begin
               item.cmd = CMD_FORCE;
               for (int i = 0; i < 8; i++) item.seed[i] = pick_seed();
               counted++;
            end else if (r < 92) begin
               item.cmd = CMD_RESTORE;
               counted++;
            end else begin
               item.cmd = CMD_NONE;
            end
            send_request(item);
            if ($urandom_range(0, 99) < 3) drain_words();
         end
      end
   endtask

   // ---------------------------------------------------------------- response side
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else if ($urandom_range(0, 99) < 25) begin
               stall_left = $urandom_range(1, 12);
            end else if ($urandom_range(0, 99) < 2) begin
               calm_left = $urandom_range(50, 300);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected transaction: random_word %h last %b seeded %b",
                   rsp_bus.random_word, rsp_bus.last, rsp_bus.seeded);
            error_count++;
         end else begin
            head_word = pending_words.pop_front();
            if (rsp_bus.random_word !== head_word.random_word) begin
               $error("random_word mismatch: expected %h, actual %h",
                      head_word.random_word, rsp_bus.random_word);
               error_count++;
            end
            if (rsp_bus.last !== head_word.last) begin
               $error("last mismatch: expected %b, actual %b", head_word.last, rsp_bus.last);
               error_count++;
            end
            if (rsp_bus.seeded !== head_word.seeded) begin
               $error("seeded mismatch: expected %b, actual %b",
                      head_word.seeded, rsp_bus.seeded);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      mult_state = MULT_RESET;
      lane_state = '0;
      saved_lane_state = '0;
      seeded_state = 1'b0;
      saved_seeded_state = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_NONE;
      req_bus.seed_x0 <= '0;
      req_bus.seed_y0 <= '0;
      req_bus.seed_x1 <= '0;
      req_bus.seed_y1 <= '0;
      req_bus.seed_x2 <= '0;
      req_bus.seed_y2 <= '0;
      req_bus.seed_x3 <= '0;
      req_bus.seed_y3 <= '0;
      req_bus.seed_flag <= 1'b0;
      req_bus.word_count <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_MULT_X0;
      csr_bus.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_unseeded_generate();
      test_seed_extremes();
      test_save_restore();
      test_word_counts();
      test_register_writes();
      test_random_traffic();

      drain_words();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/cmwc_pkg.sv
rtl/cmwc_if.sv
rtl/cmwc_mac.sv
rtl/cmwc_lane_bank.sv
rtl/cmwc_ctrl.sv
rtl/combined_mwc_random_generator_unit.sv
tb/testbench.sv
